// ----- hw/rtl/fcl_pkg.sv -----
// shared types and constants of the int8 fully connected layer core
// no dependencies; imported by the core top level
package fcl_pkg;

  // request kinds carried on the input tuser field
  typedef enum logic [1:0] {
    OP_WEIGHT = 2'd0,
    OP_BIAS   = 2'd1,
    OP_ACT    = 2'd2,
    OP_RUN    = 2'd3
  } op_t;

  // configuration register indexes
  localparam logic [0:0] CFG_INPUTS  = 1'd0;
  localparam logic [0:0] CFG_OUTPUTS = 1'd1;

  // field widths of the request and result words
  localparam int OUT_INDEX_W = 5;
  localparam int IN_INDEX_W  = 9;
  localparam int WEIGHT_W    = 8;
  localparam int BIAS_W      = 32;
  localparam int ACT_W       = 7;
  localparam int SUM_W       = 32;
  localparam int PROD_W      = 16;
  localparam int INPUTS_W    = 10;
  localparam int OUTPUTS_W   = 6;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 40;

  // most results a single run may return
  localparam int RESULT_LIMIT = 32;

  // control flags that travel with each multiply-accumulate slot
  typedef struct packed {
    logic valid;  // slot holds work
    logic mac;    // product takes part in the sum
    logic first;  // first slot of a neuron, starts from the bias
    logic stop;   // final slot of a neuron, result is ready
    logic lastn;  // slot belongs to the final neuron of the run
  } tok_t;

endpackage

// ----- hw/rtl/fcl_ram.sv -----
// generic single-port-write, single-port-read synchronous ram
// registered read with enable; no dependencies
module fcl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, held while the enable is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/int8_fully_connected_layer_core.sv -----
// top level of the int8 fully connected layer core
// uses fcl_pkg for types and constants and fcl_ram for the three stores
//
// Load requests (weight, bias, activation) are taken one per cycle while
// no run is in progress and written straight into their memories. A run
// request walks every output neuron and, for each, every active input, one
// multiply-accumulate per cycle when not stalled, through the single read
// port of the weight memory; the run holds the input until its last slot
// is issued. While a result waits in the output register and out_tready
// is low the datapath freezes, so downstream stalls hold the run.
// The stores have no reset: entries must be written before a run reads them.
module int8_fully_connected_layer_core
  import fcl_pkg::*;
#(
  parameter int MAX_INPUTS  = 512,
  parameter int MAX_OUTPUTS = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // request channel
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // in_tdata from bit 0: out_index[4:0], in_index[8:0], weight_value[7:0],
  // bias_value[31:0], activation[6:0], zero pad[2:0]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // in_tuser: op[1:0]
  input  logic [1:0]             in_tuser,
  // result channel
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // out_tdata from bit 0: neuron[4:0], sum[31:0], zero pad[2:0]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast,
  // configuration write port
  input  logic                   cfg_we,
  input  logic [0:0]             cfg_index,
  input  logic [INPUTS_W-1:0]    cfg_wdata
);

  localparam int AW       = $clog2(MAX_INPUTS);
  localparam int NINW     = $clog2(MAX_INPUTS + 1);
  localparam int NW       = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
  localparam int WDEPTH   = MAX_OUTPUTS * MAX_INPUTS;
  localparam int WAW      = $clog2(WDEPTH);
  localparam int NOUT_CAP = (MAX_OUTPUTS < RESULT_LIMIT) ? MAX_OUTPUTS : RESULT_LIMIT;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  // request fields
  op_t                    req_op;
  logic [OUT_INDEX_W-1:0] req_oi;
  logic [IN_INDEX_W-1:0]  req_ii;
  logic [WEIGHT_W-1:0]    req_w;
  logic [BIAS_W-1:0]      req_b;
  logic [ACT_W-1:0]       req_a;
  logic                   in_fire;

  assign req_op  = op_t'(in_tuser);
  assign req_oi  = in_tdata[4:0];
  assign req_ii  = in_tdata[13:5];
  assign req_w   = in_tdata[21:14];
  assign req_b   = in_tdata[53:22];
  assign req_a   = in_tdata[60:54];
  assign in_fire = in_tvalid && in_tready;

  // configuration registers
  logic [INPUTS_W-1:0]  inputs_r;
  logic [OUTPUTS_W-1:0] outputs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inputs_r  <= INPUTS_W'(32);
      outputs_r <= OUTPUTS_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INPUTS:  inputs_r  <= cfg_wdata;
        CFG_OUTPUTS: outputs_r <= cfg_wdata[OUTPUTS_W-1:0];
        default: ;
      endcase
    end
  end

  // saturated counts for a run
  logic [NINW-1:0]      nin_eff;
  logic [OUTPUTS_W-1:0] nout_eff;

  assign nin_eff  = (32'(inputs_r) > 32'(MAX_INPUTS)) ? NINW'(MAX_INPUTS) : NINW'(inputs_r);
  assign nout_eff = (32'(outputs_r) > 32'(NOUT_CAP)) ? OUTPUTS_W'(NOUT_CAP) : outputs_r;

  // store write decode
  logic           w_we, b_we, a_we;
  logic [WAW-1:0] w_waddr;

  assign w_we = in_fire && (req_op == OP_WEIGHT) && (32'(req_oi) < 32'(MAX_OUTPUTS))
                && (32'(req_ii) < 32'(MAX_INPUTS));
  assign b_we = in_fire && (req_op == OP_BIAS) && (32'(req_oi) < 32'(MAX_OUTPUTS));
  assign a_we = in_fire && (req_op == OP_ACT) && (32'(req_ii) < 32'(MAX_INPUTS));
  assign w_waddr = WAW'(32'(req_oi) * MAX_INPUTS + 32'(req_ii));

  // sequencer state
  state_t           state_r, state_nxt;
  logic [AW-1:0]    j_r, j_nxt;
  logic [NW-1:0]    n_r, n_nxt;
  logic [WAW-1:0]   base_r, base_nxt;
  logic [NINW-1:0]  nin_r, nin_nxt;
  logic [OUTPUTS_W-1:0] nout_r, nout_nxt;
  tok_t             issue_tok;
  logic             adv;

  // output register
  logic             out_valid_r;
  logic             out_last_r;
  logic [NW-1:0]    out_n_r;
  logic [SUM_W-1:0] out_sum_r;

  // the datapath moves only when the output register can take a result
  assign adv       = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE);

  // slot issued this cycle
  always_comb begin
    issue_tok.valid = (state_r == ST_RUN);
    issue_tok.mac   = (nin_r != '0);
    issue_tok.first = (j_r == '0);
    issue_tok.stop  = (nin_r == '0) || (NINW'(j_r) == nin_r - NINW'(1));
    issue_tok.lastn = (OUTPUTS_W'(n_r) == nout_r - OUTPUTS_W'(1));
  end

  // walk inputs inside each neuron, neurons inside the run
  always_comb begin
    state_nxt = state_r;
    j_nxt     = j_r;
    n_nxt     = n_r;
    base_nxt  = base_r;
    nin_nxt   = nin_r;
    nout_nxt  = nout_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && (req_op == OP_RUN) && (nout_eff != '0)) begin
          state_nxt = ST_RUN;
          j_nxt     = '0;
          n_nxt     = '0;
          base_nxt  = '0;
          nin_nxt   = nin_eff;
          nout_nxt  = nout_eff;
        end
      end
      ST_RUN: begin
        if (adv) begin
          if (issue_tok.stop) begin
            j_nxt    = '0;
            n_nxt    = n_r + NW'(1);
            base_nxt = base_r + WAW'(MAX_INPUTS);
            if (issue_tok.lastn) begin
              state_nxt = ST_IDLE;
            end
          end else begin
            j_nxt = j_r + AW'(1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      j_r     <= '0;
      n_r     <= '0;
      base_r  <= '0;
      nin_r   <= '0;
      nout_r  <= '0;
    end else begin
      state_r <= state_nxt;
      j_r     <= j_nxt;
      n_r     <= n_nxt;
      base_r  <= base_nxt;
      nin_r   <= nin_nxt;
      nout_r  <= nout_nxt;
    end
  end

  // stores
  logic [WEIGHT_W-1:0] w_rdata;
  logic [BIAS_W-1:0]   b_rdata;
  logic [ACT_W-1:0]    a_rdata;

  fcl_ram #(.WIDTH(WEIGHT_W), .DEPTH(WDEPTH)) u_weight_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (req_w),
    .re    (adv),
    .raddr (base_r + WAW'(j_r)),
    .rdata (w_rdata)
  );

  fcl_ram #(.WIDTH(BIAS_W), .DEPTH(MAX_OUTPUTS)) u_bias_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (NW'(req_oi)),
    .wdata (req_b),
    .re    (adv),
    .raddr (n_r),
    .rdata (b_rdata)
  );

  fcl_ram #(.WIDTH(ACT_W), .DEPTH(MAX_INPUTS)) u_act_ram (
    .clk   (clk),
    .we    (a_we),
    .waddr (AW'(req_ii)),
    .wdata (req_a),
    .re    (adv),
    .raddr (j_r),
    .rdata (a_rdata)
  );

  // stage 1 lines up with the memory data, stage 2 holds the product
  tok_t                s1_tok_r, s2_tok_r;
  logic [NW-1:0]       s1_n_r, s2_n_r;
  logic signed [PROD_W-1:0] prod;
  logic [PROD_W-1:0]   s2_prod_r;
  logic [BIAS_W-1:0]   s2_bias_r;
  logic [SUM_W-1:0]    acc_r, acc_nxt;

  assign prod = $signed(w_rdata) * $signed({1'b0, a_rdata});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_tok_r <= '0;
      s2_tok_r <= '0;
    end else if (adv) begin
      s1_tok_r <= issue_tok;
      s2_tok_r <= s1_tok_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_n_r    <= n_r;
      s2_n_r    <= s1_n_r;
      s2_prod_r <= s1_tok_r.mac ? prod : '0;
      s2_bias_r <= b_rdata;
    end
  end

  // accumulate, starting from the bias on the first slot of a neuron
  assign acc_nxt = (s2_tok_r.first ? s2_bias_r : acc_r)
                   + {{(SUM_W - PROD_W){s2_prod_r[PROD_W-1]}}, s2_prod_r};

  always_ff @(posedge clk) begin
    if (adv && s2_tok_r.valid) begin
      acc_r <= acc_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && s2_tok_r.valid && s2_tok_r.stop) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_tok_r.valid && s2_tok_r.stop) begin
      out_sum_r  <= acc_nxt;
      out_n_r    <= s2_n_r;
      out_last_r <= s2_tok_r.lastn;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {3'b000, out_sum_r, OUT_INDEX_W'(out_n_r)};

  // a run with results starts the sequencer
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (req_op == OP_RUN) && (nout_eff != '0)) |=> (state_r == ST_RUN))
    else $error("run request did not start the sequencer");

  // a new result only comes from a finishing slot
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s2_tok_r.valid && s2_tok_r.stop))
    else $error("result appeared without a finishing slot");

  // a frozen datapath issues nothing
  assert property (@(posedge clk) disable iff (!rst_n)
    (!adv && (state_r == ST_RUN)) |=> ($stable(j_r) && $stable(n_r) && $stable(s2_tok_r)))
    else $error("sequencer moved during a stall");

endmodule

// ----- tb/sv/tb.sv -----
// self-checking testbench for the int8 fully connected layer core
// depends on fcl_pkg and int8_fully_connected_layer_core; predicts every neuron sum
// from its own copy of the weight, bias and activation stores
module tb;
  import fcl_pkg::*;

  localparam int MAX_INPUTS  = 512;
  localparam int MAX_OUTPUTS = 32;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 16;
  localparam int LONG_HOLD = 400;

  // one request as it travels on the input channel
  typedef struct {
    op_t                op;
    logic [4:0]         out_index;
    logic [8:0]         in_index;
    logic signed [7:0]  weight;
    logic [31:0]        bias;
    logic [6:0]         act;
  } fcl_req_t;

  // one neuron result as it leaves the core
  typedef struct packed {
    logic [4:0]  neuron;
    logic [31:0] sum;
    logic        last;
  } fcl_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic out_tlast;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = CFG_INPUTS;
  logic [INPUTS_W-1:0] cfg_wdata = '0;

  always #5 clk = ~clk;

  int8_fully_connected_layer_core #(
    .MAX_INPUTS (MAX_INPUTS),
    .MAX_OUTPUTS(MAX_OUTPUTS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // predicted layer state and effective shape
  logic signed [7:0] weight_mem [MAX_OUTPUTS][MAX_INPUTS];
  logic [31:0]       bias_mem [MAX_OUTPUTS];
  logic [6:0]        act_mem [MAX_INPUTS];
  int                layer_inputs = 32;
  int                layer_outputs = 1;
  fcl_result_t       sums_due [$];

  // entries written so far, so that no run reads an unwritten one
  bit weight_set [MAX_OUTPUTS][MAX_INPUTS];
  bit bias_set [MAX_OUTPUTS];
  bit act_set [MAX_INPUTS];

  fcl_req_t pending [$];
  fcl_req_t cur_req;
  int queued_count = 0;
  int accepted_count = 0;
  int runs_taken = 0;
  int results_seen = 0;
  int mismatches = 0;
  int shapes = 1;
  int cycle_count = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int hold_left = 0;
  bit idle_on = 1'b1;
  bit long_hold_req = 1'b0;
  bit long_hold_done = 1'b0;

  // update the stores, or compute every neuron sum of a run
  task automatic take_request(input fcl_req_t r);
    logic [31:0] acc;
    logic signed [31:0] wide;
    fcl_result_t res;
    case (r.op)
      OP_WEIGHT: weight_mem[r.out_index][r.in_index] = r.weight;
      OP_BIAS:   bias_mem[r.out_index] = r.bias;
      OP_ACT:    act_mem[r.in_index] = r.act;
      OP_RUN: begin
        runs_taken++;
        for (int n = 0; n < layer_outputs; n++) begin
          acc = bias_mem[n];
          for (int j = 0; j < layer_inputs; j++) begin
            wide = weight_mem[n][j];
            acc = acc + wide * $signed({25'd0, act_mem[j]});
          end
          res.neuron = 5'(n);
          res.sum = acc;
          res.last = (n == layer_outputs - 1);
          sums_due.push_back(res);
        end
      end
      default: ;
    endcase
  endtask

  // request with every field random
  function automatic fcl_req_t rand_req();
    fcl_req_t r;
    r.op = op_t'($urandom_range(0, 3));
    r.out_index = 5'($urandom());
    r.in_index = 9'($urandom());
    r.weight = 8'($urandom());
    r.bias = $urandom();
    r.act = 7'($urandom());
    return r;
  endfunction

  // value in [lo, hi] with the ends favored
  function automatic int pick(int lo, int hi);
    case ($urandom_range(0, 7))
      0: return lo;
      1: return hi;
      default: return lo + int'($urandom_range(0, hi - lo));
    endcase
  endfunction

  function automatic logic [31:0] rand_bias();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0;
      default: return $urandom();
    endcase
  endfunction

  // load request with random filler in the fields the op ignores
  task automatic queue_write(input op_t op, input int oi, input int ii, input int val);
    fcl_req_t r;
    r = rand_req();
    r.op = op;
    case (op)
      OP_WEIGHT: begin
        r.out_index = 5'(oi);
        r.in_index = 9'(ii);
        r.weight = 8'(val);
        weight_set[r.out_index][r.in_index] = 1'b1;
      end
      OP_BIAS: begin
        r.out_index = 5'(oi);
        r.bias = 32'(val);
        bias_set[r.out_index] = 1'b1;
      end
      OP_ACT: begin
        r.in_index = 9'(ii);
        r.act = 7'(val);
        act_set[r.in_index] = 1'b1;
      end
      default: ;
    endcase
    pending.push_back(r);
    queued_count++;
  endtask

  // run request, preceded by loads of any entry it reads that is still unwritten
  task automatic queue_run();
    fcl_req_t r;
    for (int n = 0; n < layer_outputs; n++) begin
      if (!bias_set[n]) queue_write(OP_BIAS, n, 0, rand_bias());
      for (int j = 0; j < layer_inputs; j++)
        if (!weight_set[n][j]) queue_write(OP_WEIGHT, n, j, pick(-128, 127));
    end
    for (int j = 0; j < layer_inputs; j++)
      if (!act_set[j]) queue_write(OP_ACT, 0, j, pick(0, 127));
    r = rand_req();
    r.op = OP_RUN;
    pending.push_back(r);
    queued_count++;
  endtask

  // wait until the core is idle again
  task automatic settle();
    while (accepted_count != queued_count || sums_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // random loads, mostly inside the active shape, and runs
  task automatic play(input int count, input int run_pct);
    int span_in;
    int span_out;
    int oi;
    int ii;
    span_in = (layer_inputs > 0) ? layer_inputs : 1;
    span_out = (layer_outputs > 0) ? layer_outputs : 1;
    repeat (count) begin
      if ($urandom_range(0, 99) < run_pct) begin
        queue_run();
      end else begin
        oi = $urandom_range(0, MAX_OUTPUTS - 1);
        ii = $urandom_range(0, MAX_INPUTS - 1);
        if ($urandom_range(0, 4) != 0) begin
          oi = $urandom_range(0, span_out - 1);
          ii = $urandom_range(0, span_in - 1);
        end
        case ($urandom_range(0, 2))
          0: queue_write(OP_WEIGHT, oi, ii, pick(-128, 127));
          1: queue_write(OP_BIAS, oi, ii, rand_bias());
          default: queue_write(OP_ACT, oi, ii, pick(0, 127));
        endcase
      end
    end
    settle();
  endtask

  // write both shape registers; the output count carries junk above its six bits
  task automatic set_shape(input int ins, input int outs);
    logic [INPUTS_W-1:0] out_word;
    out_word = {4'($urandom()), 6'(outs)};
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_INPUTS;
    cfg_wdata <= INPUTS_W'(ins);
    @(posedge clk);
    cfg_index <= CFG_OUTPUTS;
    cfg_wdata <= out_word;
    @(posedge clk);
    cfg_we <= 1'b0;
    layer_inputs = (ins > MAX_INPUTS) ? MAX_INPUTS : ins;
    layer_outputs = (out_word[5:0] > MAX_OUTPUTS) ? MAX_OUTPUTS : int'(out_word[5:0]);
    shapes++;
    @(negedge clk);
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        take_request(cur_req);
        accepted_count++;
      end
      if (!in_tvalid || in_tready) begin
        if (send_gap != 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (pending.size() != 0) begin
          cur_req = pending.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= cur_req.op;
          in_tdata <= {3'b000, cur_req.act, cur_req.bias, cur_req.weight,
                       cur_req.in_index, cur_req.out_index};
          if (idle_on && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 16);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin : result_check
    fcl_result_t due;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (sums_due.size() == 0) begin
          $error("result with no run pending: neuron %0d sum %0d",
                 out_tdata[4:0], $signed(out_tdata[36:5]));
          mismatches++;
        end else begin
          due = sums_due.pop_front();
          if (out_tdata[4:0] !== due.neuron) begin
            $error("neuron: expected %0d, got %0d", due.neuron, out_tdata[4:0]);
            mismatches++;
          end
          if (out_tdata[36:5] !== due.sum) begin
            $error("sum: expected %0d, got %0d", $signed(due.sum), $signed(out_tdata[36:5]));
            mismatches++;
          end
          if (out_tlast !== due.last) begin
            $error("last: expected %0b, got %0b", due.last, out_tlast);
            mismatches++;
          end
        end
      end
      // one long hold-off so the core backs up into its input
      if (hold_left != 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (long_hold_req && !long_hold_done && out_tvalid) begin
        hold_left = LONG_HOLD;
        long_hold_done = 1'b1;
        out_tready <= 1'b0;
      end else if (recv_gap != 0) begin
        recv_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (idle_on && $urandom_range(0, 7) == 0) recv_gap = $urandom_range(1, 16);
      end
    end
  end

  // cycle limit
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // stimulus by layer shape
  initial begin : stimulus
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // shape left by reset
    play(15, 20);

    // extremes of weights, activations and biases, with a wrapping sum
    set_shape(2, 2);
    queue_write(OP_WEIGHT, 0, 0, 127);
    queue_write(OP_WEIGHT, 0, 1, -128);
    queue_write(OP_WEIGHT, 1, 0, -128);
    queue_write(OP_WEIGHT, 1, 1, 127);
    queue_write(OP_BIAS, 0, 0, 32'h7fff_ffff);
    queue_write(OP_BIAS, 1, 0, 32'h8000_0000);
    queue_write(OP_ACT, 0, 0, 127);
    queue_write(OP_ACT, 0, 1, 0);
    queue_run();
    queue_write(OP_ACT, 0, 1, 127);
    queue_run();
    queue_write(OP_WEIGHT, 31, 511, -1);
    queue_write(OP_BIAS, 31, 0, -1);
    queue_write(OP_ACT, 0, 511, 1);
    queue_write(OP_ACT, 0, 0, 0);
    queue_run();
    settle();

    // no inputs: bias alone
    set_shape(0, 5);
    play(15, 30);
    // output count beyond the limit saturates, then the full limit
    set_shape(3, 63);
    play(15, 25);
    set_shape(1, 32);
    play(10, 25);
    // no outputs: runs return nothing
    set_shape(7, 0);
    play(12, 30);

    // small random shapes; one hold-off early on, no idling at the end
    for (int k = 0; k < 8; k++) begin
      idle_on = (k == 7) ? 1'b0 : ($urandom_range(0, 3) != 0);
      if (k == 1) long_hold_req = 1'b1;
      set_shape(pick(0, 32), (k == 1) ? 4 : pick(1, 4));
      play(12, (k == 1) ? 50 : 20);
    end

    $display("covered %0d requests over %0d layer shapes, %0d runs",
             accepted_count, shapes, runs_taken);
    $display("checked %0d neuron sums, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
